// ----- sv/mtet_pkg.sv -----
// mtet_pkg: shared types and codes for the multi timer expiry table
// item layouts, operation modes, timer states and table defaults
// no dependencies
package mtet_pkg;

   // table size default and per-poll report limit
   localparam int NUM_TIMERS_DEF = 8;
   localparam int POLL_MAX       = 8;

   // operation modes
   localparam logic [2:0] MODE_CREATE = 3'd0;
   localparam logic [2:0] MODE_SET    = 3'd1;
   localparam logic [2:0] MODE_START  = 3'd2;
   localparam logic [2:0] MODE_CANCEL = 3'd3;
   localparam logic [2:0] MODE_TICK   = 3'd4;
   localparam logic [2:0] MODE_POLL   = 3'd5;

   // timer states
   localparam logic [1:0] TMR_UNUSED    = 2'd0;
   localparam logic [1:0] TMR_STOPPED   = 2'd1;
   localparam logic [1:0] TMR_RUNNING   = 2'd2;
   localparam logic [1:0] TMR_COMPLETED = 2'd3;

   // request item
   typedef struct packed {
      logic [2:0]  mode;
      logic [2:0]  timer_idx;
      logic [31:0] period;
      logic        periodic;
   } req_type;

   // response item
   typedef struct packed {
      logic       ok;
      logic       fired;
      logic [2:0] fired_id;
      logic       last;
   } rsp_type;

   // one timer table entry
   typedef struct packed {
      logic [1:0]  state;
      logic        periodic;
      logic [31:0] period;
      logic [31:0] expiry;
   } entry_type;

endpackage

// ----- sv/multi_timer_expiry_table.sv -----
// multi_timer_expiry_table: table of one-shot and periodic timers on a tick count
// timer setup lives in one synchronous memory, pending flags in flops
// depends on mtet_pkg
//
// Each request item is taken one at a time and gives one response item, except
// a poll, which gives one per pending timer (at most eight, lowest number first,
// last set on the final one) or a single empty one if none is pending. Create,
// set period, start and cancel do a read, modify and write of one table entry
// and pass through the exec and reply states before the response enters the
// output register. A tick walks the whole table through the single memory read
// port, one entry per cycle. A poll scans the pending flags one timer per cycle
// and waits on each report while the output register is held by a stall. A new
// item can be taken while the previous response still waits in the output
// register. Per-entry valid bits make unwritten entries read as unused, so no
// clearing pass is run after reset.
module multi_timer_expiry_table #(
   parameter int NUM_TIMERS = mtet_pkg::NUM_TIMERS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  mtet_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output mtet_pkg::rsp_type rsp_data
);

   localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int CNT_W = $clog2(NUM_TIMERS + 1);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_EXEC  = 3'd1;
   localparam logic [2:0] S_TICK  = 3'd2;
   localparam logic [2:0] S_POLL  = 3'd3;
   localparam logic [2:0] S_REPLY = 3'd4;

   logic [2:0]            fsm_ff, fsm_in;
   mtet_pkg::req_type     item_ff, item_in;
   logic [CNT_W-1:0]      walk_ff, walk_in;
   logic                  proc_vld_ff, proc_vld_in;
   logic [IDX_W-1:0]      proc_idx_ff, proc_idx_in;
   logic [2:0]            poll_cnt_ff, poll_cnt_in;
   logic                  reply_ok_ff, reply_ok_in;
   logic [31:0]           tick_count_ff, tick_count_in;
   logic [NUM_TIMERS-1:0] valid_ff, valid_in;
   logic [NUM_TIMERS-1:0] pend_ff, pend_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   mtet_pkg::rsp_type     rsp_data_ff, rsp_data_in;

   mtet_pkg::entry_type   mem [NUM_TIMERS];
   mtet_pkg::entry_type   rd_data_ff;
   logic [IDX_W-1:0]      rd_addr;
   logic                  mem_we;
   mtet_pkg::entry_type   mem_wdata;

   mtet_pkg::entry_type   cur;
   logic                  accept;
   logic                  out_free;
   logic                  id_ok;
   logic                  walk_done;
   logic [IDX_W-1:0]      walk_idx;
   logic                  pend_here;
   logic                  pend_above;
   logic                  poll_last;
   logic                  emit;
   mtet_pkg::rsp_type     emit_data;

   // handshake
   assign req_stall = (fsm_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // entry under work; an entry never written reads as unused
   assign cur = valid_ff[proc_idx_ff] ? rd_data_ff : '0;

   // scan helpers
   assign id_ok     = (32'(req_data.timer_idx) < NUM_TIMERS);
   assign walk_done = (walk_ff == CNT_W'(NUM_TIMERS));
   assign walk_idx  = walk_ff[IDX_W-1:0];
   assign pend_here = !walk_done && pend_ff[walk_idx];

   // any pending timer beyond the one being reported
   always_comb begin
      pend_above = 1'b0;
      for (int j = 0; j < NUM_TIMERS; j++) begin
         if (CNT_W'(j) > walk_ff) begin
            pend_above = pend_above | pend_ff[j];
         end
      end
   end

   assign poll_last = !pend_above ||
                      (poll_cnt_ff == 3'(mtet_pkg::POLL_MAX - 1));

   // control and datapath
   always_comb begin
      fsm_in        = fsm_ff;
      item_in       = item_ff;
      walk_in       = walk_ff;
      proc_vld_in   = proc_vld_ff;
      proc_idx_in   = proc_idx_ff;
      poll_cnt_in   = poll_cnt_ff;
      reply_ok_in   = reply_ok_ff;
      tick_count_in = tick_count_ff;
      pend_in       = pend_ff;
      rd_addr       = walk_idx;
      mem_we        = 1'b0;
      mem_wdata     = cur;
      emit          = 1'b0;
      emit_data     = '0;
      emit_data.ok  = 1'b1;
      emit_data.last = 1'b1;

      case (fsm_ff)
         S_IDLE: begin
            rd_addr = IDX_W'(req_data.timer_idx);
            if (accept) begin
               item_in     = req_data;
               proc_idx_in = IDX_W'(req_data.timer_idx);
               proc_vld_in = 1'b0;
               walk_in     = '0;
               poll_cnt_in = '0;
               if (req_data.mode inside {mtet_pkg::MODE_CREATE, mtet_pkg::MODE_SET,
                                         mtet_pkg::MODE_START, mtet_pkg::MODE_CANCEL}) begin
                  if (id_ok) begin
                     fsm_in = S_EXEC;
                  end else begin
                     reply_ok_in = 1'b0;
                     fsm_in      = S_REPLY;
                  end
               end else if (req_data.mode == mtet_pkg::MODE_TICK) begin
                  tick_count_in = tick_count_ff + 32'd1;
                  fsm_in        = S_TICK;
               end else if (req_data.mode == mtet_pkg::MODE_POLL) begin
                  fsm_in = S_POLL;
               end else begin
                  reply_ok_in = 1'b0;
                  fsm_in      = S_REPLY;
               end
            end
         end

         // single-entry update, read data now available
         S_EXEC: begin
            reply_ok_in = 1'b0;
            case (item_ff.mode)
               mtet_pkg::MODE_CREATE: begin
                  mem_wdata.state    = mtet_pkg::TMR_STOPPED;
                  mem_wdata.periodic = item_ff.periodic;
                  mem_wdata.period   = item_ff.period;
                  mem_wdata.expiry   = '0;
                  mem_we             = 1'b1;
                  pend_in[proc_idx_ff] = 1'b0;
                  reply_ok_in        = 1'b1;
               end
               mtet_pkg::MODE_SET: begin
                  mem_wdata.period   = item_ff.period;
                  mem_we             = 1'b1;
                  pend_in[proc_idx_ff] = 1'b0;
                  reply_ok_in        = 1'b1;
               end
               mtet_pkg::MODE_START: begin
                  if (cur.state != mtet_pkg::TMR_UNUSED) begin
                     mem_wdata.state  = mtet_pkg::TMR_RUNNING;
                     mem_wdata.expiry = cur.period + tick_count_ff;
                     mem_we           = 1'b1;
                     reply_ok_in      = 1'b1;
                  end
               end
               mtet_pkg::MODE_CANCEL: begin
                  if (cur.state == mtet_pkg::TMR_RUNNING) begin
                     mem_wdata.state = mtet_pkg::TMR_STOPPED;
                     mem_we          = 1'b1;
                     reply_ok_in     = 1'b1;
                  end
               end
               default: begin
                  reply_ok_in = 1'b0;
               end
            endcase
            fsm_in = S_REPLY;
         end

         // table walk: read one entry ahead, update the one just read
         S_TICK: begin
            if (!walk_done) begin
               walk_in     = walk_ff + CNT_W'(1);
               proc_vld_in = 1'b1;
               proc_idx_in = walk_idx;
            end else begin
               proc_vld_in = 1'b0;
            end
            if (proc_vld_ff && cur.state == mtet_pkg::TMR_RUNNING &&
                tick_count_ff >= cur.expiry) begin
               pend_in[proc_idx_ff] = 1'b1;
               mem_we               = 1'b1;
               if (cur.periodic) begin
                  mem_wdata.expiry = tick_count_ff + cur.period;
               end else begin
                  mem_wdata.state = mtet_pkg::TMR_COMPLETED;
               end
            end
            if (walk_done && !proc_vld_ff) begin
               reply_ok_in = 1'b1;
               fsm_in      = S_REPLY;
            end
         end

         // pending scan, one timer per cycle unless a report waits on a stalled output
         S_POLL: begin
            if (walk_done) begin
               if (out_free) begin
                  emit   = 1'b1;
                  fsm_in = S_IDLE;
               end
            end else if (pend_here) begin
               if (out_free) begin
                  emit               = 1'b1;
                  emit_data.fired    = 1'b1;
                  emit_data.fired_id = 3'(walk_ff);
                  emit_data.last     = poll_last;
                  pend_in[walk_idx]  = 1'b0;
                  poll_cnt_in        = poll_cnt_ff + 3'd1;
                  if (poll_last) begin
                     fsm_in = S_IDLE;
                  end else begin
                     walk_in = walk_ff + CNT_W'(1);
                  end
               end
            end else begin
               walk_in = walk_ff + CNT_W'(1);
            end
         end

         S_REPLY: begin
            if (out_free) begin
               emit         = 1'b1;
               emit_data.ok = reply_ok_ff;
               fsm_in       = S_IDLE;
            end
         end

         default: begin
            fsm_in = S_IDLE;
         end
      endcase
   end

   // entry valid bits follow the writes
   always_comb begin
      valid_in = valid_ff;
      if (mem_we) begin
         valid_in[proc_idx_ff] = 1'b1;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = emit_data;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // timer table memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[proc_idx_ff] <= mem_wdata;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff        <= S_IDLE;
         proc_vld_ff   <= 1'b0;
         tick_count_ff <= '0;
         valid_ff      <= '0;
         pend_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         fsm_ff        <= fsm_in;
         proc_vld_ff   <= proc_vld_in;
         tick_count_ff <= tick_count_in;
         valid_ff      <= valid_in;
         pend_ff       <= pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      walk_ff     <= walk_in;
      proc_idx_ff <= proc_idx_in;
      poll_cnt_ff <= poll_cnt_in;
      reply_ok_ff <= reply_ok_in;
      rsp_data_ff <= rsp_data_in;
   end

   // table writes only come from an entry update or a tick walk with data
   a_write_source: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (fsm_ff == S_EXEC || (fsm_ff == S_TICK && proc_vld_ff)))
      else $error("table write outside an update");

   // a reported timer has its pending flag cleared
   a_poll_clears: assert property (@(posedge clock) disable iff (reset)
      (emit && emit_data.fired) |=> !pend_ff[$past(walk_idx)])
      else $error("reported timer still pending");

   // the eighth report of a poll closes it
   a_poll_limit: assert property (@(posedge clock) disable iff (reset)
      (emit && fsm_ff == S_POLL && poll_cnt_ff == 3'(mtet_pkg::POLL_MAX - 1))
         |-> emit_data.last)
      else $error("poll reported past its limit");

   // the tick count moves only on an accepted tick
   a_tick_only: assert property (@(posedge clock) disable iff (reset)
      !$stable(tick_count_ff) |-> $past(accept && req_data.mode == mtet_pkg::MODE_TICK))
      else $error("tick count changed without a tick");

endmodule
